@@ src/assert_macros.svh @@
// assertion macros used by the rtl file pcp_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// when the antecedent holds, the consequent holds in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// when the antecedent holds, the consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/pcp_pkg.sv @@
// shared types and constants of the pinned cache policy block
`timescale 1ns / 1ps
`default_nettype none
package pcp_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_DROPS = 16;
  localparam int DROP_W    = 5;

  localparam logic [30:0] LIFE_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] PINS_MAX = 16'hFFFF;

  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_GET  = 3'd1;
  localparam logic [2:0] ACT_REL  = 3'd2;
  localparam logic [2:0] ACT_INV  = 3'd3;
  localparam logic [2:0] ACT_TRIM = 3'd4;

  localparam logic [2:0] EV_ADDED     = 3'd0;
  localparam logic [2:0] EV_DATA      = 3'd1;
  localparam logic [2:0] EV_DROPPED   = 3'd2;
  localparam logic [2:0] EV_DONE      = 3'd3;
  localparam logic [2:0] EV_UNDERFLOW = 3'd4;
  localparam logic [2:0] EV_NO_SLOT   = 3'd5;
  localparam logic [2:0] EV_EMPTY     = 3'd6;

  typedef struct packed {
    logic [23:0] cost;
    logic [30:0] life;
    logic [15:0] pins;
    logic [31:0] tag;
  } entry_t;

endpackage
`default_nettype wire

@@ src/pcp_slot_mem.sv @@
// slot entry memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module pcp_slot_mem #(
  parameter int SLOTS = pcp_pkg::SLOTS_DEF,
  parameter int AW    = 4
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire pcp_pkg::entry_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output pcp_pkg::entry_t     rdata
);

  pcp_pkg::entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/pcp_ctrl.sv @@
// sequencer: decodes commands, sweeps the slot memory, keeps flags and byte count
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pcp_ctrl #(
  parameter int SLOTS = pcp_pkg::SLOTS_DEF,
  parameter int AW    = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire logic [2:0]     action,
  input  wire logic [3:0]     slot_index,
  input  wire logic [23:0]    byte_cost,
  input  wire logic [31:0]    object_tag,
  input  wire logic [23:0]    byte_budget,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output pcp_pkg::entry_t     mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  wire pcp_pkg::entry_t mem_rdata,
  output logic                result_strobe,
  output logic [2:0]          event_res,
  output logic [3:0]          slot_out,
  output logic [31:0]         tag_out,
  output logic                is_temporary,
  output logic                last
);

  localparam int PW = AW + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_CHK  = 4'd1;
  localparam logic [3:0] S_TRIM_CHK = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_EVICT    = 4'd4;
  localparam logic [3:0] S_ADD_WR   = 4'd5;
  localparam logic [3:0] S_AGE      = 4'd6;
  localparam logic [3:0] S_RD       = 4'd7;

  logic [3:0]              state;
  logic [SLOTS-1:0]        valid;
  logic [SLOTS-1:0]        temp;
  logic [23:0]             used;
  logic [pcp_pkg::DROP_W-1:0] drops;
  logic                    temp_f;
  logic                    is_trim;
  logic [2:0]              op_action;
  logic [3:0]              op_idx;
  logic [23:0]             op_cost;
  logic [31:0]             op_tag;
  logic [PW-1:0]           ptr;
  logic                    pv;
  logic [AW-1:0]           pa;
  logic                    found;
  logic [AW-1:0]           best_idx;
  logic [30:0]             best_life;
  logic [31:0]             best_tag;
  logic [23:0]             best_cost;
  logic                    best_temp;

  logic [AW-1:0]           in_a;
  logic                    in_bad;
  logic [AW-1:0]           op_a;
  logic                    sweep_more;
  logic                    sweep_end;
  logic                    over_add;
  logic [AW-1:0]           free_idx;
  logic                    free_ok;
  logic                    cand;
  logic                    rd_en;
  logic [23:0]             used_less;

  assign busy       = (state != S_IDLE);
  assign in_a       = AW'(slot_index);
  assign in_bad     = (32'(slot_index) >= SLOTS) || !valid[in_a];
  assign op_a       = AW'(op_idx);
  assign sweep_more = (ptr < PW'(SLOTS));
  assign sweep_end  = !sweep_more && !pv;
  assign over_add   = ({1'b0, used} + {1'b0, op_cost}) > {1'b0, byte_budget};
  assign cand       = pv && valid[pa] && (mem_rdata.pins == 16'd0) &&
                      (!found || (mem_rdata.life < best_life));
  assign used_less  = (used >= best_cost) ? (used - best_cost) : 24'd0;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid[s]) begin
        free_idx = AW'(s);
        free_ok  = 1'b1;
      end
    end
  end

  // memory read address
  always_comb begin
    rd_en     = 1'b0;
    mem_raddr = ptr[AW-1:0];
    if (state == S_IDLE) begin
      mem_raddr = in_a;
      rd_en     = start && !in_bad &&
                  (action == pcp_pkg::ACT_GET || action == pcp_pkg::ACT_REL ||
                   action == pcp_pkg::ACT_INV);
    end else if (state == S_SCAN || state == S_AGE) begin
      rd_en = sweep_more;
    end
  end

  // memory write back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pa;
    mem_wdata = mem_rdata;
    case (state)
      S_AGE: begin
        mem_we = pv && valid[pa];
        if (mem_rdata.life != pcp_pkg::LIFE_MAX) begin
          mem_wdata.life = mem_rdata.life + 31'd1;
        end
        if (pa == op_a && mem_rdata.pins != pcp_pkg::PINS_MAX) begin
          mem_wdata.pins = mem_rdata.pins + 16'd1;
        end
      end
      S_RD: begin
        mem_waddr      = op_a;
        mem_we         = (op_action == pcp_pkg::ACT_REL) && !temp[op_a] &&
                         (mem_rdata.pins != 16'd0);
        mem_wdata.pins = mem_rdata.pins - 16'd1;
      end
      S_ADD_WR: begin
        mem_waddr = free_idx;
        mem_we    = free_ok;
        mem_wdata = '{cost: op_cost, life: 31'd0, pins: 16'd0, tag: op_tag};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid         <= '0;
      temp          <= '0;
      used          <= '0;
      drops         <= '0;
      pv            <= 1'b0;
      found         <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      last          <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_action <= action;
            op_idx    <= slot_index;
            op_cost   <= byte_cost;
            op_tag    <= object_tag;
            drops     <= '0;
            ptr       <= '0;
            pv        <= 1'b0;
            case (action)
              pcp_pkg::ACT_ADD: begin
                temp_f  <= byte_cost > byte_budget;
                is_trim <= 1'b0;
                state   <= S_ADD_CHK;
              end
              pcp_pkg::ACT_GET, pcp_pkg::ACT_REL, pcp_pkg::ACT_INV: begin
                if (in_bad) begin
                  result_strobe <= 1'b1;
                  event_res     <= pcp_pkg::EV_EMPTY;
                  slot_out      <= slot_index;
                  tag_out       <= '0;
                  is_temporary  <= 1'b0;
                  last          <= 1'b1;
                end else if (action == pcp_pkg::ACT_GET) begin
                  state <= S_AGE;
                end else begin
                  state <= S_RD;
                end
              end
              pcp_pkg::ACT_TRIM: begin
                is_trim <= 1'b1;
                state   <= S_TRIM_CHK;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD_CHK: begin
          ptr   <= '0;
          pv    <= 1'b0;
          found <= 1'b0;
          if (temp_f || !over_add) begin
            state <= S_ADD_WR;
          end else if (drops >= pcp_pkg::DROP_W'(pcp_pkg::MAX_DROPS)) begin
            temp_f <= 1'b1;
            state  <= S_ADD_WR;
          end else begin
            state <= S_SCAN;
          end
        end
        S_TRIM_CHK: begin
          ptr   <= '0;
          pv    <= 1'b0;
          found <= 1'b0;
          if (used > byte_budget && drops < pcp_pkg::DROP_W'(pcp_pkg::MAX_DROPS)) begin
            state <= S_SCAN;
          end else begin
            result_strobe <= 1'b1;
            event_res     <= pcp_pkg::EV_DONE;
            slot_out      <= '0;
            tag_out       <= '0;
            is_temporary  <= 1'b0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SCAN: begin
          pv <= sweep_more;
          pa <= ptr[AW-1:0];
          if (sweep_more) begin
            ptr <= ptr + PW'(1);
          end
          if (cand) begin
            found     <= 1'b1;
            best_idx  <= pa;
            best_life <= mem_rdata.life;
            best_tag  <= mem_rdata.tag;
            best_cost <= mem_rdata.cost;
            best_temp <= temp[pa];
          end
          if (sweep_end) begin
            if (found) begin
              state <= S_EVICT;
            end else if (is_trim) begin
              result_strobe <= 1'b1;
              event_res     <= pcp_pkg::EV_DONE;
              slot_out      <= '0;
              tag_out       <= '0;
              is_temporary  <= 1'b0;
              last          <= 1'b1;
              state         <= S_IDLE;
            end else begin
              temp_f <= 1'b1;
              state  <= S_ADD_WR;
            end
          end
        end
        S_EVICT: begin
          result_strobe  <= 1'b1;
          event_res      <= pcp_pkg::EV_DROPPED;
          slot_out       <= 4'(best_idx);
          tag_out        <= best_tag;
          is_temporary   <= best_temp;
          valid[best_idx] <= 1'b0;
          temp[best_idx]  <= 1'b0;
          if (!best_temp) begin
            used <= used_less;
          end
          drops <= drops + pcp_pkg::DROP_W'(1);
          state <= is_trim ? S_TRIM_CHK : S_ADD_CHK;
        end
        S_ADD_WR: begin
          result_strobe <= 1'b1;
          last          <= 1'b1;
          tag_out       <= op_tag;
          if (!free_ok) begin
            event_res    <= pcp_pkg::EV_NO_SLOT;
            slot_out     <= '0;
            is_temporary <= 1'b0;
          end else begin
            event_res       <= pcp_pkg::EV_ADDED;
            slot_out        <= 4'(free_idx);
            is_temporary    <= temp_f;
            valid[free_idx] <= 1'b1;
            temp[free_idx]  <= temp_f;
            if (!temp_f) begin
              used <= used + op_cost;
            end
          end
          state <= S_IDLE;
        end
        S_AGE: begin
          pv <= sweep_more;
          pa <= ptr[AW-1:0];
          if (sweep_more) begin
            ptr <= ptr + PW'(1);
          end
          if (pv && pa == op_a) begin
            best_tag <= mem_rdata.tag;
          end
          if (sweep_end) begin
            result_strobe <= 1'b1;
            event_res     <= pcp_pkg::EV_DATA;
            slot_out      <= op_idx;
            tag_out       <= best_tag;
            is_temporary  <= temp[op_a];
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_RD: begin
          result_strobe <= 1'b1;
          last          <= 1'b1;
          slot_out      <= op_idx;
          tag_out       <= mem_rdata.tag;
          // only a temporary entry reports the mark, and it is always dropped
          is_temporary  <= temp[op_a];
          if (op_action == pcp_pkg::ACT_INV || temp[op_a]) begin
            event_res    <= pcp_pkg::EV_DROPPED;
            valid[op_a]  <= 1'b0;
            temp[op_a]   <= 1'b0;
            if (!temp[op_a]) begin
              used <= (used >= mem_rdata.cost) ? (used - mem_rdata.cost) : 24'd0;
            end
          end else if (mem_rdata.pins == 16'd0) begin
            event_res <= pcp_pkg::EV_UNDERFLOW;
          end else begin
            event_res <= pcp_pkg::EV_DONE;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_drop_bound, 1'b1, drops <= pcp_pkg::DROP_W'(pcp_pkg::MAX_DROPS))
  `ASSERT_SAME(a_evict_has_victim, state == S_EVICT, found)
  `ASSERT_SAME(a_no_rw_clash, mem_we && rd_en, mem_waddr != mem_raddr)
  `ASSERT_NEXT(a_quiet_idle, state == S_IDLE && !start, !result_strobe)

endmodule
`default_nettype wire

@@ src/pinned_size_bounded_cache_policy.sv @@
// top level of the pinned, byte-bounded slot cache policy engine
`timescale 1ns / 1ps
`default_nettype none
// commands are taken when start is high and busy is low; each result word
// shows for exactly one cycle with result_strobe high, and the receiver
// cannot stall, so it must take every strobed word. last marks the final
// word of a command and shows in the cycle in which busy falls. a bad slot
// or an unknown action does not raise busy. release and invalidate read one
// slot; get makes one read-modify-write sweep over the slot memory to age
// all entries; trim and add run one minimum-life search per victim evicted,
// at most 16 victims. a search that finds no victim ends a trim or makes an
// add temporary. each search reads every slot through the one read port of
// the slot memory. the user must see that byte_budget is written over the
// cfg channel only while busy is low; the block does not enforce it.
module pinned_size_bounded_cache_policy #(
  parameter int SLOTS = pcp_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [3:0]  slot_index,
  input  wire logic [23:0] byte_cost,
  input  wire logic [31:0] object_tag,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data,
  output logic             result_strobe,
  output logic [2:0]       event_res,
  output logic [3:0]       slot_out,
  output logic [31:0]      tag_out,
  output logic             is_temporary,
  output logic             last
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // budget register, always writable
  logic [23:0] byte_budget;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  pcp_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_raddr;
  pcp_pkg::entry_t mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_budget <= '0;
    end else if (cfg_valid && cfg_ready) begin
      byte_budget <= cfg_data;
    end
  end

  // sequencer with slot flags and used byte count
  pcp_ctrl #(.SLOTS(SLOTS), .AW(AW)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .slot_index    (slot_index),
    .byte_cost     (byte_cost),
    .object_tag    (object_tag),
    .byte_budget   (byte_budget),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .result_strobe (result_strobe),
    .event_res     (event_res),
    .slot_out      (slot_out),
    .tag_out       (tag_out),
    .is_temporary  (is_temporary),
    .last          (last)
  );

  // cost, life, pins and tag per slot
  pcp_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

@@ tb/pinned_size_bounded_cache_policy_tb.sv @@
// testbench of the pinned cache policy block: random and directed commands, scoreboard check
`timescale 1ns / 1ps
module pinned_size_bounded_cache_policy_tb;

  localparam int NSLOT = 16;

  // one result word of the block
  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic        temp;
    logic        fin;
  } word_t;

  // scoreboard: mirror of the slot table and a queue of expected words
  class cache_scoreboard;
    bit          valid [NSLOT];
    bit          temp  [NSLOT];
    bit [23:0]   cost  [NSLOT];
    bit [30:0]   life  [NSLOT];
    bit [15:0]   pins  [NSLOT];
    bit [31:0]   tag   [NSLOT];
    bit [23:0]   used;
    bit [23:0]   budget;
    word_t       pending[$];
    int          errors;

    function new();
      budget = 0;
      used = 0;
      errors = 0;
      foreach (valid[i]) begin
        valid[i] = 0;
        temp[i] = 0;
      end
    endfunction

    function void push_word(logic [2:0] e, logic [3:0] s, logic [31:0] t, logic tp);
      word_t w;
      w.ev = e;
      w.slot = s;
      w.tag = t;
      w.temp = tp;
      w.fin = 0;
      pending.push_back(w);
    endfunction

    function void drop(int s);
      if (!temp[s]) used = (used >= cost[s]) ? used - cost[s] : 24'd0;
      valid[s] = 0;
      temp[s] = 0;
    endfunction

    // least-life unpinned victim, lowest slot on a tie
    function bit evict_least_life();
      int best;
      best = -1;
      for (int s = 0; s < NSLOT; s++)
        if (valid[s] && pins[s] == 0 && (best < 0 || life[s] < life[best])) best = s;
      if (best < 0) return 0;
      push_word(pcp_pkg::EV_DROPPED, best[3:0], tag[best], temp[best]);
      drop(best);
      return 1;
    endfunction

    // note an accepted command and queue the words it causes
    function void note_command(logic [2:0] act, logic [3:0] idx, logic [23:0] c,
                               logic [31:0] t);
      int n0, drops, free_slot;
      bit tp;
      n0 = pending.size();
      drops = 0;
      free_slot = -1;
      if (act == pcp_pkg::ACT_ADD) begin
        tp = c > budget;
        if (!tp)
          while ({1'b0, used} + c > budget) begin
            if (drops >= pcp_pkg::MAX_DROPS || !evict_least_life()) begin
              tp = 1;
              break;
            end
            drops++;
          end
        for (int s = 0; s < NSLOT; s++)
          if (!valid[s] && free_slot < 0) free_slot = s;
        if (free_slot < 0) push_word(pcp_pkg::EV_NO_SLOT, 4'd0, t, 1'b0);
        else begin
          valid[free_slot] = 1;
          temp[free_slot] = tp;
          cost[free_slot] = c;
          life[free_slot] = 0;
          pins[free_slot] = 0;
          tag[free_slot] = t;
          if (!tp) used = used + c;
          push_word(pcp_pkg::EV_ADDED, free_slot[3:0], t, tp);
        end
      end else if (act == pcp_pkg::ACT_TRIM) begin
        while (used > budget && drops < pcp_pkg::MAX_DROPS) begin
          if (!evict_least_life()) break;
          drops++;
        end
        push_word(pcp_pkg::EV_DONE, 4'd0, 32'd0, 1'b0);
      end else if (act <= pcp_pkg::ACT_INV) begin
        if (!valid[idx]) push_word(pcp_pkg::EV_EMPTY, idx, 32'd0, 1'b0);
        else if (act == pcp_pkg::ACT_GET) begin
          for (int s = 0; s < NSLOT; s++)
            if (valid[s] && life[s] < pcp_pkg::LIFE_MAX) life[s]++;
          if (pins[idx] < pcp_pkg::PINS_MAX) pins[idx]++;
          push_word(pcp_pkg::EV_DATA, idx, tag[idx], temp[idx]);
        end else if (act == pcp_pkg::ACT_REL) begin
          if (temp[idx]) begin
            push_word(pcp_pkg::EV_DROPPED, idx, tag[idx], 1'b1);
            drop(idx);
          end else if (pins[idx] == 0)
            push_word(pcp_pkg::EV_UNDERFLOW, idx, tag[idx], 1'b0);
          else begin
            pins[idx]--;
            push_word(pcp_pkg::EV_DONE, idx, tag[idx], 1'b0);
          end
        end else begin
          push_word(pcp_pkg::EV_DROPPED, idx, tag[idx], temp[idx]);
          drop(idx);
        end
      end
      if (pending.size() > n0) pending[pending.size() - 1].fin = 1;
    endfunction

    // compare one strobed word with the oldest expectation
    function void check_word(word_t got);
      word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.ev !== want.ev) begin
        $display("%0t: event_res expected %0d actual %0d", $realtime, want.ev, got.ev);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: slot_out expected %0d actual %0d", $realtime, want.slot, got.slot);
        errors++;
      end
      if (got.tag !== want.tag) begin
        $display("%0t: tag_out expected %h actual %h", $realtime, want.tag, got.tag);
        errors++;
      end
      if (got.temp !== want.temp) begin
        $display("%0t: is_temporary expected %0d actual %0d", $realtime, want.temp,
                 got.temp);
        errors++;
      end
      if (got.fin !== want.fin) begin
        $display("%0t: last expected %0d actual %0d", $realtime, want.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [2:0]  action = '0;
  logic [3:0]  slot_index = '0;
  logic [23:0] byte_cost = '0;
  logic [31:0] object_tag = '0;
  logic        cfg_valid = 0;
  logic [23:0] cfg_data = '0;
  wire         busy, cfg_ready, result_strobe, is_temporary, last;
  wire  [2:0]  event_res;
  wire  [3:0]  slot_out;
  wire  [31:0] tag_out;

  cache_scoreboard sb = new();
  bit idle_ok = 1;   // random gaps between commands while set

  pinned_size_bounded_cache_policy dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .slot_index(slot_index), .byte_cost(byte_cost), .object_tag(object_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .event_res(event_res), .slot_out(slot_out),
    .tag_out(tag_out), .is_temporary(is_temporary), .last(last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result words are checked at the edge that takes them
  always @(posedge clk)
    if (!rst && result_strobe)
      sb.check_word({event_res, slot_out, tag_out, is_temporary, last});

  // drive one command and hold it until the block takes it; start stays high
  // for a following command and is dropped by a gap or by drain
  task automatic send_cmd(logic [2:0] a, logic [3:0] s, logic [23:0] c, logic [31:0] t);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    action <= a;
    slot_index <= s;
    byte_cost <= c;
    object_tag <= t;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_command(a, s, c, t);
    @(negedge clk);
  endtask

  // wait until every expected word is back, then let the block settle
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // budget write, only while the block is idle
  task automatic write_budget(logic [23:0] b);
    cfg_data <= b;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.budget = b;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // mostly small costs so budgets are hit often; slots drawn uniformly from 0 to 15
  task automatic random_cmd();
    logic [2:0]  a;
    logic [3:0]  s;
    logic [23:0] c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) a = pcp_pkg::ACT_ADD;
    else if (pick < 60) a = pcp_pkg::ACT_GET;
    else if (pick < 80) a = pcp_pkg::ACT_REL;
    else if (pick < 88) a = pcp_pkg::ACT_INV;
    else if (pick < 97) a = pcp_pkg::ACT_TRIM;
    else a = 3'($urandom_range(5, 7));
    s = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) c = 24'($urandom);
    else c = 24'($urandom_range(0, 300));
    send_cmd(a, s, c, $urandom);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: budget zero makes every sized add temporary
    send_cmd(pcp_pkg::ACT_ADD, 4'd0, 24'd0, 32'hFFFF_FFFF);
    send_cmd(pcp_pkg::ACT_ADD, 4'd0, 24'hFF_FFFF, 32'h0000_0000);
    send_cmd(pcp_pkg::ACT_GET, 4'd1, 24'd0, 32'd0);
    send_cmd(pcp_pkg::ACT_REL, 4'd1, 24'd0, 32'd0);   // temporary dropped on release
    send_cmd(pcp_pkg::ACT_REL, 4'd0, 24'd0, 32'd0);   // underflow
    send_cmd(pcp_pkg::ACT_GET, 4'd15, 24'd0, 32'd0);  // empty slot
    send_cmd(pcp_pkg::ACT_REL, 4'd9, 24'd0, 32'd0);
    send_cmd(pcp_pkg::ACT_INV, 4'd0, 24'd0, 32'd0);
    send_cmd(3'd7, 4'd0, 24'd0, 32'd0);               // unknown action
    send_cmd(pcp_pkg::ACT_TRIM, 4'd0, 24'd0, 32'd0);
    drain();
    write_budget(24'd100);
    // fill the table, then force evictions and the full-table case
    for (int i = 0; i < 17; i++) send_cmd(pcp_pkg::ACT_ADD, 4'd0, 24'd5, $urandom);
    send_cmd(pcp_pkg::ACT_GET, 4'd3, 24'd0, 32'd0);   // pin and age
    send_cmd(pcp_pkg::ACT_GET, 4'd3, 24'd0, 32'd0);
    send_cmd(pcp_pkg::ACT_REL, 4'd3, 24'd0, 32'd0);
    send_cmd(pcp_pkg::ACT_ADD, 4'd0, 24'd90, 32'h1234_5678); // many victims
    drain();
    write_budget(24'd10);
    send_cmd(pcp_pkg::ACT_TRIM, 4'd0, 24'd0, 32'd0);
    drain();

    // random phases over several budgets, the extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_budget(24'hFF_FFFF);
        1: write_budget(24'd0);
        default: write_budget(24'($urandom_range(50, 1500)));
      endcase
      if (ph == 5) idle_ok = 0;
      for (int i = 0; i < 50; i++) random_cmd();
      drain();                                      // sender waits for all words
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+src
src/pcp_pkg.sv
src/pcp_slot_mem.sv
src/pcp_ctrl.sv
src/pinned_size_bounded_cache_policy.sv
tb/pinned_size_bounded_cache_policy_tb.sv
